// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the 1-Wire master RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define OW_ASSERT_AT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Concurrent assertion on the module's clk and rst_n.
`define OW_ASSERT(lbl, prop, msg) \
    `OW_ASSERT_AT(lbl, clk, rst_n, prop, msg)

`endif

// ===== rtl/owm_pkg.sv =====
// Shared types and constants of the 1-Wire bus master.
// No dependencies; used by the engine, the top level and the testbench.
`default_nettype none

package owm_pkg;

    localparam int unsigned TIMER_W = 10;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [7:0] WRITE_ZERO_RECOVER_US = 8'd2;
    localparam logic [7:0] READ_RECOVER_US = 8'd60;

    localparam logic [2:0] FN_NONE = 3'd0;
    localparam logic [2:0] FN_RESET = 3'd1;
    localparam logic [2:0] FN_WRITE_BIT = 3'd2;
    localparam logic [2:0] FN_WRITE_BYTE = 3'd3;
    localparam logic [2:0] FN_READ_BIT = 3'd4;
    localparam logic [2:0] FN_READ_BYTE = 3'd5;

    localparam logic [2:0] REG_RESET_LOW = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [2:0] REG_RESET_TAIL = 3'd2;
    localparam logic [2:0] REG_WRITE_ONE_LOW = 3'd3;
    localparam logic [2:0] REG_WRITE_ONE_HIGH = 3'd4;
    localparam logic [2:0] REG_WRITE_ZERO_LOW = 3'd5;
    localparam logic [2:0] REG_READ_LOW = 3'd6;
    localparam logic [2:0] REG_READ_SAMPLE = 3'd7;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [9:0] presence_wait_us;
        logic [9:0] reset_tail_us;
        logic [7:0] write_one_low_us;
        logic [7:0] write_one_high_us;
        logic [7:0] write_zero_low_us;
        logic [7:0] read_low_us;
        logic [7:0] read_sample_us;
    } cfg_t;

    typedef struct packed {
        logic       tick;
        logic [2:0] func;
        logic [7:0] data_in;
        logic       bus_level;
    } cmd_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       no_presence;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/owm_if.sv =====
// Valid/ready channel interfaces for commands and results of the 1-Wire master.
// No dependencies.
`default_nettype none

interface owm_cmd_if;
    logic       valid;
    logic       ready;
    logic       tick;
    logic [2:0] func;
    logic [7:0] data_in;
    logic       bus_level;

    modport source (output valid, output tick, output func, output data_in,
                    output bus_level, input ready);
    modport sink (input valid, input tick, input func, input data_in,
                  input bus_level, output ready);
endinterface

interface owm_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_presence;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output read_data, output no_presence, input ready);
    modport sink (input valid, input drive_low, input busy_res, input done_res,
                  input read_data, input no_presence, output ready);
endinterface

`default_nettype wire

// ===== rtl/one_wire_bus_master_core.sv =====
// Top level of the 1-Wire bus master: configuration registers and result register.
// Depends on owm_pkg, owm_if.sv and owm_engine.
//
//   Channel   Direction  Carries
//   cmd_ch    in         tick, func, data_in, bus_level
//   res_ch    out        drive_low, busy_res, done_res, read_data, no_presence
//   wr_*      in         configuration writes (wr_en, wr_index, wr_data)
//
// Every command transaction yields exactly one result transaction, offered the next cycle.
// Unless stalled, one transaction is accepted per cycle; each updates the sequencer once.
// The single result register stalls input only while it is full and not being taken.
// Reset loads the documented register defaults and puts the sequencer in idle.
`default_nettype none

module one_wire_bus_master_core
    import owm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    owm_cmd_if.sink                     cmd_ch,
    owm_res_if.source                   res_ch,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data
);

    cfg_t cfg_reg;
    cmd_t cmd;
    res_t res_next;
    res_t res_reg;
    logic out_valid_reg, out_valid_next;
    logic step;

    assign cmd_ch.ready = !out_valid_reg || res_ch.ready;
    assign step = cmd_ch.valid && cmd_ch.ready;
    assign out_valid_next = step || (out_valid_reg && !res_ch.ready);

    always_comb
    begin
        cmd.tick = cmd_ch.tick;
        cmd.func = cmd_ch.func;
        cmd.data_in = cmd_ch.data_in;
        cmd.bus_level = cmd_ch.bus_level;
    end

    owm_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cmd   (cmd),
        .cfg   (cfg_reg),
        .res   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_us <= 10'd600;
            cfg_reg.presence_wait_us <= 10'd100;
            cfg_reg.reset_tail_us <= 10'd800;
            cfg_reg.write_one_low_us <= 8'd8;
            cfg_reg.write_one_high_us <= 8'd80;
            cfg_reg.write_zero_low_us <= 8'd80;
            cfg_reg.read_low_us <= 8'd2;
            cfg_reg.read_sample_us <= 8'd5;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_RESET_LOW:      cfg_reg.reset_low_us <= wr_data;
                REG_PRESENCE_WAIT:  cfg_reg.presence_wait_us <= wr_data;
                REG_RESET_TAIL:     cfg_reg.reset_tail_us <= wr_data;
                REG_WRITE_ONE_LOW:  cfg_reg.write_one_low_us <= wr_data[7:0];
                REG_WRITE_ONE_HIGH: cfg_reg.write_one_high_us <= wr_data[7:0];
                REG_WRITE_ZERO_LOW: cfg_reg.write_zero_low_us <= wr_data[7:0];
                REG_READ_LOW:       cfg_reg.read_low_us <= wr_data[7:0];
                REG_READ_SAMPLE:    cfg_reg.read_sample_us <= wr_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign res_ch.valid = out_valid_reg;
    assign res_ch.drive_low = res_reg.drive_low;
    assign res_ch.busy_res = res_reg.busy_res;
    assign res_ch.done_res = res_reg.done_res;
    assign res_ch.read_data = res_reg.read_data;
    assign res_ch.no_presence = res_reg.no_presence;

endmodule

`default_nettype wire

// ===== rtl/owm_engine.sv =====
// Slot sequencer of the 1-Wire master: phase, slot timer, bit counter, shifter.
// Depends on owm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module owm_engine
    import owm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire cmd_t cmd,
    input  wire cfg_t cfg,
    output res_t      res
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_WR_LOW,
        PH_WR_HIGH,
        PH_RD_LOW,
        PH_RD_WAIT,
        PH_RD_REC
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [TIMER_W-1:0]   timer_reg, timer_next;
    logic [3:0]           bits_reg, bits_next;
    logic [7:0]           shift_reg, shift_next;
    logic [2:0]           kind_reg, kind_next;
    logic                 presence_reg, presence_next;
    logic [3:0]           bits_dec;
    logic                 done;
    logic [7:0]           rdata;

    function automatic logic [TIMER_W-1:0] dur(input logic [TIMER_W-1:0] us);
        dur = (us == '0) ? TIMER_W'(1) : us;
    endfunction

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        bits_next = bits_reg;
        shift_next = shift_reg;
        kind_next = kind_reg;
        presence_next = presence_reg;
        done = 1'b0;
        rdata = 8'd0;
        bits_dec = (bits_reg != 4'd0) ? bits_reg - 4'd1 : 4'd0;

        if (phase_reg == PH_IDLE)
        begin
            case (cmd.func)
                FN_RESET:
                begin
                    kind_next = cmd.func;
                    phase_next = PH_RST_LOW;
                    timer_next = dur(cfg.reset_low_us);
                end
                FN_WRITE_BIT, FN_WRITE_BYTE:
                begin
                    kind_next = cmd.func;
                    shift_next = (cmd.func == FN_WRITE_BIT) ? {7'd0, cmd.data_in[0]}
                                                            : cmd.data_in;
                    bits_next = (cmd.func == FN_WRITE_BIT) ? 4'd1 : 4'd8;
                    phase_next = PH_WR_LOW;
                    timer_next = dur(shift_next[0] ? {2'd0, cfg.write_one_low_us}
                                                   : {2'd0, cfg.write_zero_low_us});
                end
                FN_READ_BIT, FN_READ_BYTE:
                begin
                    kind_next = cmd.func;
                    shift_next = 8'd0;
                    bits_next = (cmd.func == FN_READ_BIT) ? 4'd1 : 4'd8;
                    phase_next = PH_RD_LOW;
                    timer_next = dur({2'd0, cfg.read_low_us});
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.tick)
        begin
            if (timer_reg > TIMER_W'(1))
            begin
                timer_next = timer_reg - TIMER_W'(1);
            end
            else
            begin
                timer_next = '0;
                case (phase_reg)
                    PH_RST_LOW:
                    begin
                        phase_next = PH_RST_WAIT;
                        timer_next = dur(cfg.presence_wait_us);
                    end
                    PH_RST_WAIT:
                    begin
                        presence_next = cmd.bus_level;
                        phase_next = PH_RST_TAIL;
                        timer_next = dur(cfg.reset_tail_us);
                    end
                    PH_WR_LOW:
                    begin
                        phase_next = PH_WR_HIGH;
                        timer_next = dur(shift_reg[0] ? {2'd0, cfg.write_one_high_us}
                                                      : {2'd0, WRITE_ZERO_RECOVER_US});
                    end
                    PH_WR_HIGH:
                    begin
                        shift_next = {1'b0, shift_reg[7:1]};
                        bits_next = bits_dec;
                        if (bits_dec != 4'd0)
                        begin
                            phase_next = PH_WR_LOW;
                            timer_next = dur(shift_next[0] ? {2'd0, cfg.write_one_low_us}
                                                           : {2'd0, cfg.write_zero_low_us});
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            done = 1'b1;
                        end
                    end
                    PH_RD_LOW:
                    begin
                        phase_next = PH_RD_WAIT;
                        timer_next = dur({2'd0, cfg.read_sample_us});
                    end
                    PH_RD_WAIT:
                    begin
                        shift_next = (kind_reg == FN_READ_BIT) ? {7'd0, cmd.bus_level}
                                                               : {cmd.bus_level, shift_reg[7:1]};
                        phase_next = PH_RD_REC;
                        timer_next = dur({2'd0, READ_RECOVER_US});
                    end
                    PH_RD_REC:
                    begin
                        bits_next = bits_dec;
                        if (bits_dec != 4'd0)
                        begin
                            phase_next = PH_RD_LOW;
                            timer_next = dur({2'd0, cfg.read_low_us});
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            done = 1'b1;
                            rdata = shift_reg;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        done = 1'b1;
                    end
                endcase
            end
        end

        res.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW)
                        || (phase_next == PH_RD_LOW);
        res.busy_res = (phase_next != PH_IDLE);
        res.done_res = done;
        res.read_data = rdata;
        res.no_presence = presence_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            bits_reg <= 4'd0;
            shift_reg <= 8'd0;
            kind_reg <= FN_NONE;
            presence_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bits_reg <= bits_next;
            shift_reg <= shift_next;
            kind_reg <= kind_next;
            presence_reg <= presence_next;
        end
    end

    `OW_ASSERT(a_hold_without_step, !step |=> $stable(phase_reg) && $stable(timer_reg), "state changed without a transaction")
    `OW_ASSERT(a_timer_live, phase_reg != PH_IDLE |-> timer_reg != '0, "active phase with an empty slot timer")
    `OW_ASSERT(a_done_from_last_phase, step && res.done_res |-> phase_reg == PH_WR_HIGH || phase_reg == PH_RD_REC || phase_reg == PH_RST_TAIL, "completion outside a final phase")
    `OW_ASSERT(a_bits_range, bits_reg <= 4'd8, "bit counter out of range")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for one_wire_bus_master_core: directed and random command streams under
// varied handshake pressure, each result checked against a cycle model of the sequencer.
// Depends on owm_pkg and on the channel interfaces in owm_if.sv.
module tb_top;
    import owm_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 24;
    localparam int ITEMS_PER_SETTING = 12;
    localparam int MAX_REPORTS = 10;
    localparam int LEVEL_RANDOM = 2;
    localparam logic [2:0] FN_RSVD_6 = 3'd6;
    localparam logic [2:0] FN_RSVD_7 = 3'd7;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_RST_LOW,
        SEQ_RST_WAIT,
        SEQ_RST_TAIL,
        SEQ_WR_LOW,
        SEQ_WR_HIGH,
        SEQ_RD_LOW,
        SEQ_RD_WAIT,
        SEQ_RD_REC
    } seq_phase_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    owm_cmd_if cmd_ch();
    owm_res_if res_ch();

    one_wire_bus_master_core i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_ch(cmd_ch),
        .res_ch(res_ch),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data)
    );

    cfg_t timing;
    seq_phase_t seq_phase;
    logic [TIMER_W-1:0] slot_left;
    logic [3:0] bits_left;
    logic [7:0] shift_reg;
    logic [2:0] cmd_kind;
    logic presence_bit;

    res_t line_expect_q[$];
    int fail_count;
    int idle_pct;
    int stall_pct;
    bit hold_active;
    event start_hold;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= !hold_active && ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(start_hold);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    // Sequencer model, advanced once per accepted command transaction.
    function automatic void arm_slot(seq_phase_t ph, logic [TIMER_W-1:0] us);
        seq_phase = ph;
        slot_left = (us == '0) ? TIMER_W'(1) : us;
    endfunction

    function automatic void begin_write_slot();
        arm_slot(SEQ_WR_LOW, shift_reg[0] ? TIMER_W'(timing.write_one_low_us)
                                          : TIMER_W'(timing.write_zero_low_us));
    endfunction

    function automatic res_t advance_master(cmd_t c);
        res_t r;
        r = '0;
        if (seq_phase == SEQ_IDLE)
        begin
            case (c.func)
                FN_RESET:
                begin
                    cmd_kind = c.func;
                    arm_slot(SEQ_RST_LOW, timing.reset_low_us);
                end
                FN_WRITE_BIT, FN_WRITE_BYTE:
                begin
                    cmd_kind = c.func;
                    shift_reg = (c.func == FN_WRITE_BIT) ? {7'b0, c.data_in[0]} : c.data_in;
                    bits_left = (c.func == FN_WRITE_BIT) ? 4'd1 : 4'd8;
                    begin_write_slot();
                end
                FN_READ_BIT, FN_READ_BYTE:
                begin
                    cmd_kind = c.func;
                    shift_reg = 8'h00;
                    bits_left = (c.func == FN_READ_BIT) ? 4'd1 : 4'd8;
                    arm_slot(SEQ_RD_LOW, TIMER_W'(timing.read_low_us));
                end
                default:
                begin
                end
            endcase
        end
        else if (c.tick)
        begin
            if (slot_left > TIMER_W'(1))
            begin
                slot_left = slot_left - TIMER_W'(1);
            end
            else
            begin
                slot_left = '0;
                case (seq_phase)
                    SEQ_RST_LOW:
                    begin
                        arm_slot(SEQ_RST_WAIT, timing.presence_wait_us);
                    end
                    SEQ_RST_WAIT:
                    begin
                        presence_bit = c.bus_level;
                        arm_slot(SEQ_RST_TAIL, timing.reset_tail_us);
                    end
                    SEQ_WR_LOW:
                    begin
                        arm_slot(SEQ_WR_HIGH, shift_reg[0] ? TIMER_W'(timing.write_one_high_us)
                                                           : TIMER_W'(WRITE_ZERO_RECOVER_US));
                    end
                    SEQ_WR_HIGH:
                    begin
                        shift_reg = shift_reg >> 1;
                        if (bits_left != 4'd0)
                        begin
                            bits_left = bits_left - 4'd1;
                        end
                        if (bits_left != 4'd0)
                        begin
                            begin_write_slot();
                        end
                        else
                        begin
                            seq_phase = SEQ_IDLE;
                            r.done_res = 1'b1;
                        end
                    end
                    SEQ_RD_LOW:
                    begin
                        arm_slot(SEQ_RD_WAIT, TIMER_W'(timing.read_sample_us));
                    end
                    SEQ_RD_WAIT:
                    begin
                        if (cmd_kind == FN_READ_BIT)
                        begin
                            shift_reg = {7'b0, c.bus_level};
                        end
                        else
                        begin
                            shift_reg = {c.bus_level, shift_reg[7:1]};
                        end
                        arm_slot(SEQ_RD_REC, TIMER_W'(READ_RECOVER_US));
                    end
                    SEQ_RD_REC:
                    begin
                        if (bits_left != 4'd0)
                        begin
                            bits_left = bits_left - 4'd1;
                        end
                        if (bits_left != 4'd0)
                        begin
                            arm_slot(SEQ_RD_LOW, TIMER_W'(timing.read_low_us));
                        end
                        else
                        begin
                            seq_phase = SEQ_IDLE;
                            r.done_res = 1'b1;
                            r.read_data = shift_reg;
                        end
                    end
                    default:
                    begin
                        seq_phase = SEQ_IDLE;
                        r.done_res = 1'b1;
                    end
                endcase
            end
        end
        r.drive_low = (seq_phase == SEQ_RST_LOW) || (seq_phase == SEQ_WR_LOW) ||
                      (seq_phase == SEQ_RD_LOW);
        r.busy_res = (seq_phase != SEQ_IDLE);
        r.no_presence = presence_bit;
        return r;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%t: %s", $realtime, msg);
        end
    endfunction

    always @(posedge clk)
    begin : check_result
        res_t got;
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.drive_low = res_ch.drive_low;
            got.busy_res = res_ch.busy_res;
            got.done_res = res_ch.done_res;
            got.read_data = res_ch.read_data;
            got.no_presence = res_ch.no_presence;
            if (line_expect_q.size() == 0)
            begin
                note_failure($sformatf("unexpected result transaction %h", got));
            end
            else
            begin
                want = line_expect_q.pop_front();
                if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
                    got.done_res !== want.done_res || got.read_data !== want.read_data ||
                    got.no_presence !== want.no_presence)
                begin
                    note_failure($sformatf({"mismatch: expected drive_low=%b busy=%b done=%b ",
                        "read_data=%h no_presence=%b, got drive_low=%b busy=%b done=%b ",
                        "read_data=%h no_presence=%b"},
                        want.drive_low, want.busy_res, want.done_res, want.read_data,
                        want.no_presence, got.drive_low, got.busy_res, got.done_res,
                        got.read_data, got.no_presence));
                end
            end
        end
    end

    function automatic cmd_t make_item(logic tick, logic [2:0] func, logic [7:0] data,
                                       logic level);
        cmd_t c;
        c.tick = tick;
        c.func = func;
        c.data_in = data;
        c.bus_level = level;
        return c;
    endfunction

    task automatic send_item(input cmd_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.tick <= c.tick;
        cmd_ch.func <= c.func;
        cmd_ch.data_in <= c.data_in;
        cmd_ch.bus_level <= c.bus_level;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        line_expect_q.push_back(advance_master(c));
    endtask

    // Runs the model to idle with ignored noise, then waits for every result.
    task automatic drain_to_idle();
        while (seq_phase != SEQ_IDLE)
        begin
            send_item(make_item(1'b1, 3'($urandom_range(7)), 8'($urandom),
                                1'($urandom_range(1))));
        end
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (line_expect_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [9:0] value);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(posedge clk);
        case (idx)
            REG_RESET_LOW: timing.reset_low_us = value;
            REG_PRESENCE_WAIT: timing.presence_wait_us = value;
            REG_RESET_TAIL: timing.reset_tail_us = value;
            REG_WRITE_ONE_LOW: timing.write_one_low_us = value[7:0];
            REG_WRITE_ONE_HIGH: timing.write_one_high_us = value[7:0];
            REG_WRITE_ZERO_LOW: timing.write_zero_low_us = value[7:0];
            REG_READ_LOW: timing.read_low_us = value[7:0];
            REG_READ_SAMPLE: timing.read_sample_us = value[7:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic program_timing(input logic [9:0] rst_low, input logic [9:0] pres_wait,
                                  input logic [9:0] rst_tail, input logic [9:0] one_low,
                                  input logic [9:0] one_high, input logic [9:0] zero_low,
                                  input logic [9:0] rd_low, input logic [9:0] rd_sample);
        drain_to_idle();
        write_reg(REG_RESET_LOW, rst_low);
        write_reg(REG_PRESENCE_WAIT, pres_wait);
        write_reg(REG_RESET_TAIL, rst_tail);
        write_reg(REG_WRITE_ONE_LOW, one_low);
        write_reg(REG_WRITE_ONE_HIGH, one_high);
        write_reg(REG_WRITE_ZERO_LOW, zero_low);
        write_reg(REG_READ_LOW, rd_low);
        write_reg(REG_READ_SAMPLE, rd_sample);
        wr_en <= 1'b0;
    endtask

    function automatic logic [9:0] pick_duration();
        return 10'($urandom_range(5));
    endfunction

    task automatic program_random_timing();
        program_timing(pick_duration(), pick_duration(), pick_duration(), pick_duration(),
                       pick_duration(), pick_duration(), pick_duration(), pick_duration());
    endtask

    task automatic run_cmd(input logic [2:0] func, input logic [7:0] data, input int level);
        send_item(make_item(1'($urandom_range(1)), func, data, 1'b1));
        while (seq_phase != SEQ_IDLE)
        begin
            send_item(make_item(1'b1, FN_NONE, 8'h00,
                                (level == LEVEL_RANDOM) ? 1'($urandom_range(1)) : level[0]));
        end
    endtask

    // Byte reads are long and are left to the directed tests.
    function automatic cmd_t random_item();
        cmd_t c;
        int roll;
        c.data_in = 8'($urandom);
        c.bus_level = 1'($urandom_range(1));
        if (seq_phase == SEQ_IDLE)
        begin
            c.tick = 1'($urandom_range(1));
            roll = $urandom_range(99);
            if (roll < 80)
            begin
                c.func = 3'($urandom_range(FN_RESET, FN_READ_BIT));
            end
            else if (roll < 90)
            begin
                c.func = FN_NONE;
            end
            else
            begin
                c.func = $urandom_range(1) ? FN_RSVD_6 : FN_RSVD_7;
            end
        end
        else
        begin
            c.tick = ($urandom_range(99) < 85);
            c.func = 3'($urandom_range(7));
        end
        return c;
    endfunction

    task automatic test_default_timing();
        run_cmd(FN_WRITE_BIT, 8'h01, 1);
    endtask

    task automatic test_each_command();
        program_timing(10'd3, 10'd2, 10'd4, 10'd1, 10'd2, 10'd3, 10'd1, 10'd2);
        run_cmd(FN_RESET, 8'h00, 1);
        run_cmd(FN_WRITE_BIT, 8'hFE, 0);
        run_cmd(FN_WRITE_BIT, 8'h01, 0);
        run_cmd(FN_WRITE_BYTE, 8'h00, 1);
        run_cmd(FN_WRITE_BYTE, 8'hA5, 1);
        run_cmd(FN_READ_BIT, 8'h00, 1);
        run_cmd(FN_RESET, 8'h00, 0);
        send_item(make_item(1'b1, FN_RSVD_6, 8'hFF, 1'b0));
        send_item(make_item(1'b0, FN_RSVD_7, 8'h00, 1'b1));
        send_item(make_item(1'b1, FN_NONE, 8'hFF, 1'b1));
        run_cmd(FN_READ_BIT, 8'hFF, 0);
    endtask

    task automatic test_busy_commands();
        send_item(make_item(1'b1, FN_WRITE_BYTE, 8'h3C, 1'b0));
        while (seq_phase != SEQ_IDLE)
        begin
            send_item(make_item(1'($urandom_range(1)), 3'($urandom_range(FN_RESET, FN_RSVD_7)),
                                8'($urandom), 1'($urandom_range(1))));
        end
    endtask

    task automatic test_zero_timing();
        program_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        run_cmd(FN_RESET, 8'h00, 1);
        run_cmd(FN_WRITE_BYTE, 8'h5A, 0);
        run_cmd(FN_READ_BYTE, 8'h00, LEVEL_RANDOM);
        run_cmd(FN_WRITE_BIT, 8'h01, 0);
    endtask

    // Upper data bits are dropped by the 8-bit registers.
    task automatic test_wide_writes();
        program_timing(10'd3, 10'd2, 10'd1, 10'h201, 10'h102, 10'h303, 10'h100, 10'h302);
        run_cmd(FN_WRITE_BYTE, 8'hA5, 1);
        run_cmd(FN_RESET, 8'h00, 1);
    endtask

    // The receiver holds off while commands keep coming, so the block must stall input.
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        program_timing(10'd2, 10'd1, 10'd2, 10'd1, 10'd2, 10'd2, 10'd1, 10'd1);
        -> start_hold;
        repeat (30) send_item(random_item());
        drain_to_idle();
        repeat (10) send_item(random_item());
    endtask

    task automatic test_random(input int idle, input int stall);
        int counted;
        int next_setting;
        cmd_t c;
        idle_pct = idle;
        stall_pct = stall;
        counted = 0;
        next_setting = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted >= next_setting)
            begin
                program_random_timing();
                next_setting += ITEMS_PER_SETTING;
            end
            c = random_item();
            if ((seq_phase == SEQ_IDLE) ? (c.func >= FN_RESET && c.func <= FN_READ_BYTE)
                                        : c.tick)
            begin
                counted++;
            end
            send_item(c);
        end
        drain_to_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.tick = 1'b0;
        cmd_ch.func = FN_NONE;
        cmd_ch.data_in = 8'h00;
        cmd_ch.bus_level = 1'b1;
        fail_count = 0;
        timing.reset_low_us = 10'd600;
        timing.presence_wait_us = 10'd100;
        timing.reset_tail_us = 10'd800;
        timing.write_one_low_us = 8'd8;
        timing.write_one_high_us = 8'd80;
        timing.write_zero_low_us = 8'd80;
        timing.read_low_us = 8'd2;
        timing.read_sample_us = 8'd5;
        seq_phase = SEQ_IDLE;
        slot_left = '0;
        bits_left = '0;
        shift_reg = '0;
        cmd_kind = '0;
        presence_bit = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_timing();
        test_each_command();
        test_busy_commands();
        test_zero_timing();
        test_wide_writes();
        test_backpressure();
        test_random(0, 0);
        test_random(47, 0);
        test_random(0, 47);
        test_random(10, 10);

        drain_to_idle();
        repeat (20) @(posedge clk);
        if (line_expect_q.size() != 0)
        begin
            note_failure($sformatf("%0d expected results never arrived",
                                   line_expect_q.size()));
        end
        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/owm_pkg.sv
rtl/owm_if.sv
rtl/owm_engine.sv
rtl/one_wire_bus_master_core.sv
dv/tb_top.sv
